// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file latent_class_posterior.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define LCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define LCP_ASSERT(lbl, clk, rstn, prop)
`define LCP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/lcp_pkg.sv =====
// Shared types, constants and saturating arithmetic for the latent class posterior block.
// Depends on nothing.
package lcp_pkg;
    localparam int MAX_CLASSES = 8;
    localparam int MAX_VARS    = 64;
    localparam int MAX_CATS    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int TBL_DEPTH   = MAX_VARS * MAX_CATS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int CORR_LEN    = 48;

    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;

    localparam logic [1:0] CMD_TABLE = 2'd0;
    localparam logic [1:0] CMD_PRIOR = 2'd1;
    localparam logic [1:0] CMD_RESP  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_VLOAD, S_LSE, S_OUT, S_WAIT
    } t_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [5:0]        var_index;
        logic [2:0]        class_index;
        logic [3:0]        category_index;
        logic signed [31:0] log_value;
        logic [4:0]        response;
        logic              last_variable;
    } t_in;

    typedef struct packed {
        logic [2:0]         out_class;
        logic signed [31:0] log_posterior;
        logic signed [31:0] obs_log_lik;
        logic               last;
    } t_out;

    typedef struct packed {
        logic              tbl_we;
        logic              prior_we;
        logic [TBL_AW-1:0] addr;
        logic signed [31:0] wdata;
        logic              rd_en;
        logic              acc_add;
        logic              clear;
        logic              v_load;
        logic              shift;
    } t_cell_ctl;

    function automatic logic signed [31:0] clamp33(input logic signed [32:0] s);
        logic signed [31:0] r;
        if (s > 33'sh0_7FFF_FFFF)      r = POS_MAX;
        else if (s < -33'sh0_8000_0000) r = NEG_INF;
        else                            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [31:0] r;
        if (a == NEG_INF || b == NEG_INF) r = NEG_INF;
        else r = clamp33(33'(a) + 33'(b));
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [31:0] r;
        if (a == NEG_INF) r = NEG_INF;
        else r = clamp33(33'(a) - 33'(b));
        return r;
    endfunction

    // ln(1+e^-(q/4)) in Q0.16
    function automatic logic [15:0] corr_q16(input logic [5:0] q);
        logic [15:0] r;
        case (q)
            6'd0: r = 16'd45426;  6'd1: r = 16'd37745;  6'd2: r = 16'd31069;
            6'd3: r = 16'd25354;  6'd4: r = 16'd20530;  6'd5: r = 16'd16510;
            6'd6: r = 16'd13200;  6'd7: r = 16'd10500;  6'd8: r = 16'd8318;
            6'd9: r = 16'd6567;   6'd10: r = 16'd5170;  6'd11: r = 16'd4061;
            6'd12: r = 16'd3184;  6'd13: r = 16'd2493;  6'd14: r = 16'd1950;
            6'd15: r = 16'd1523;  6'd16: r = 16'd1189;  6'd17: r = 16'd928;
            6'd18: r = 16'd724;   6'd19: r = 16'd565;   6'd20: r = 16'd440;
            6'd21: r = 16'd343;   6'd22: r = 16'd267;   6'd23: r = 16'd208;
            6'd24: r = 16'd162;   6'd25: r = 16'd126;   6'd26: r = 16'd98;
            6'd27: r = 16'd77;    6'd28: r = 16'd60;    6'd29: r = 16'd47;
            6'd30: r = 16'd36;    6'd31: r = 16'd28;    6'd32: r = 16'd22;
            6'd33: r = 16'd17;    6'd34: r = 16'd13;    6'd35: r = 16'd10;
            6'd36: r = 16'd8;     6'd37: r = 16'd6;     6'd38: r = 16'd5;
            6'd39: r = 16'd4;     6'd40: r = 16'd3;     6'd41: r = 16'd2;
            6'd42: r = 16'd2;     6'd43: r = 16'd1;     6'd44: r = 16'd1;
            6'd45: r = 16'd1;     6'd46: r = 16'd1;     6'd47: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction
endpackage

// ===== sv/latent_class_posterior.sv =====
// Top level of the latent class posterior block: control sequencer, log-sum-exp unit
// and the ring of class cells. Depends on lcp_pkg, lcp_cell and assert_macros.svh.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+--------------------------
//  request  | i_valid | o_ready | i_data (t_in)
//  result   | o_valid | i_ready | o_data (t_out)
//  config   | i_cfg_we| -       | i_cfg_data (num_classes)
//
// Loads are written when the request is taken. A response reads the bank,
// then accumulates; every class cell reads its own table bank in the same cycle.
// On the last variable the cells form prior plus sum, the cell ring is walked
// through the log-add unit, then each result is formed and held until taken.
// Reset (synchronous, active low) clears the sums and the sequencer; the table
// and priors hold garbage until loaded. A stalled result holds the sequencer.
`include "assert_macros.svh"
module latent_class_posterior
    import lcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);
    t_state             r_state, n_state;
    logic [3:0]         r_ncls;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   w_nuse;
    logic               r_resp_ok, r_last;
    logic signed [31:0] r_lik, n_lik;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    t_cell_ctl          w_ctl;
    logic               w_in_acc, w_out_acc;
    logic [3:0]         w_resp_cat;
    logic signed [31:0] w_v [MAX_CLASSES];

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_out_valid && i_ready;

    // observed category is the response code minus one
    assign w_resp_cat = i_data.response[3:0] - 4'd1;

    // classes in use: zero acts as one, clamp at the cell count
    always_comb begin
        if (r_ncls == 4'd0)                       w_nuse = CNT_W'(1);
        else if (32'(r_ncls) > MAX_CLASSES)       w_nuse = CNT_W'(MAX_CLASSES);
        else                                      w_nuse = CNT_W'(r_ncls);
    end

    function automatic logic signed [31:0] log_add(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [31:0]          hi, lo, r;
        logic [32:0]                 d;
        logic [33:0]                 q;
        logic [FRAC_BITS+16:0]       c;
        if (x == NEG_INF) r = y;
        else if (y == NEG_INF) r = x;
        else begin
            if (x < y) begin hi = y; lo = x; end
            else begin hi = x; lo = y; end
            d = 33'(33'(hi) - 33'(lo));
            q = (34'(d) + 34'(1 << (FRAC_BITS - 3))) >> (FRAC_BITS - 2);
            if (q >= 34'(CORR_LEN)) r = hi;
            else begin
                c = ((FRAC_BITS+17)'(corr_q16(q[5:0])) << FRAC_BITS)
                    + (FRAC_BITS+17)'(32768);
                c = c >> 16;
                r = clamp33(33'(hi) + 33'(c));
            end
        end
        return r;
    endfunction

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncls <= 4'd2;
        end else if (i_cfg_we) begin
            r_ncls <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && i_data.cmd == CMD_RESP) n_state = S_ADD;
            S_ADD:   n_state = r_last ? S_VLOAD : S_IDLE;
            S_VLOAD: n_state = S_LSE;
            S_LSE:   if (r_cnt == CNT_W'(MAX_CLASSES - 1)) n_state = S_OUT;
            S_OUT:   n_state = S_WAIT;
            S_WAIT:  if (w_out_acc) n_state = (r_cnt + 1'b1 == w_nuse) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and cell controls
    always_comb begin
        w_ctl         = '0;
        w_ctl.addr    = {i_data.var_index, i_data.category_index};
        w_ctl.wdata   = i_data.log_value;
        n_cnt         = r_cnt;
        n_lik         = r_lik;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        o_ready       = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_data.cmd)
                        CMD_TABLE: w_ctl.tbl_we = 1'b1;
                        CMD_PRIOR: w_ctl.prior_we = 1'b1;
                        CMD_RESP: begin
                            w_ctl.rd_en = 1'b1;
                            w_ctl.addr  = {i_data.var_index, w_resp_cat};
                        end
                        default:   ;
                    endcase
                end
            end
            S_ADD: begin
                w_ctl.acc_add = r_resp_ok;
            end
            S_VLOAD: begin
                w_ctl.v_load = 1'b1;
                n_cnt        = '0;
                n_lik        = NEG_INF;
            end
            S_LSE: begin
                // advance the ring; cell 0 feeds the log-add unit
                w_ctl.shift = 1'b1;
                if (r_cnt < w_nuse) n_lik = log_add(r_lik, w_v[0]);
                n_cnt = (r_cnt == CNT_W'(MAX_CLASSES - 1)) ? '0 : r_cnt + 1'b1;
            end
            S_OUT: begin
                n_out_valid         = 1'b1;
                n_out.out_class     = r_cnt[CLS_W-1:0];
                n_out.log_posterior = sat_sub(w_v[0], r_lik);
                n_out.obs_log_lik   = r_lik;
                n_out.last          = (r_cnt + 1'b1 == w_nuse);
            end
            S_WAIT: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == w_nuse) begin
                        w_ctl.clear = 1'b1;
                        n_cnt       = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers; hold the response flags taken with the request
    always_ff @(posedge i_clk) begin
        r_lik <= n_lik;
        r_out <= n_out;
        if (w_in_acc) begin
            r_resp_ok <= (i_data.response != 5'd0) && (32'(i_data.response) <= MAX_CATS);
            r_last    <= i_data.last_variable;
        end
    end

    // ring of class cells, each handing its value to the neighbor below
    for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
        lcp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_sel   (i_data.class_index == CLS_W'(k)),
            .i_use   (CNT_W'(k) < w_nuse),
            .i_v     (w_v[(k + 1) % MAX_CLASSES]),
            .o_v     (w_v[k])
        );
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `LCP_ASSERT_IMP(a_no_req_while_out, i_clk, i_rst_n, o_valid, !o_ready)
    `LCP_ASSERT_IMP(a_last_class, i_clk, i_rst_n, o_valid && o_data.last,
                    CNT_W'(o_data.out_class) + 1'b1 == w_nuse)
    `LCP_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(o_valid), $past(r_state) == S_OUT)
endmodule

// ===== sv/lcp_cell.sv =====
// One class cell: table bank, prior, accumulator and ring value register.
// Depends on lcp_pkg.
module lcp_cell
    import lcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic               i_sel,
    input  logic               i_use,
    input  logic signed [31:0] i_v,
    output logic signed [31:0] o_v
);
    logic signed [31:0] r_mem [TBL_DEPTH];
    logic signed [31:0] r_rd;
    logic signed [31:0] r_prior;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tbl_we && i_sel) begin
            r_mem[i_ctl.addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prior_we && i_sel) begin
            r_prior <= i_ctl.wdata;
        end
        if (i_ctl.v_load) begin
            r_v <= sat_add(r_prior, r_acc);
        end else if (i_ctl.shift) begin
            r_v <= i_v;
        end
    end

    // drop the sum back to zero on reset and once an observation is delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc_add && i_use) begin
            r_acc <= sat_add(r_acc, r_rd);
        end
    end

    assign o_v = r_v;
endmodule
